FILE: src/rrrs_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin redraw scheduler: shared definitions
// Command codes, the decoded command that travels from the front end to the
// execution engine, and the result record that the engine emits.
// ----------------------------------------------------------------------------
package rrrs_pkg;

  // Default sizes of the widget and channel stores.
  localparam int MAX_WIDGETS_DEF = 24;
  localparam int CHANNELS_DEF    = 16;

  // Entries in the queue between the front end and the execution engine.
  localparam int QUEUE_DEPTH = 2;

  // Command codes as they arrive on the input channel.
  localparam logic [2:0] CMD_SET  = 3'd0;
  localparam logic [2:0] CMD_POLL = 3'd1;
  localparam logic [2:0] CMD_MAP  = 3'd2;
  localparam logic [2:0] CMD_DRAW = 3'd3;
  localparam logic [2:0] CMD_READ = 3'd4;

  // Result kinds.
  localparam logic KIND_REDRAW = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Operations that survive decoding and need the execution engine.
  typedef enum logic [2:0] {
    OP_SET,
    OP_POLL,
    OP_MAP,
    OP_DRAW,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [4:0]         channel;
    logic [4:0]         widget_index;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [4:0]         widget;
    logic [4:0]         channel;
    logic signed [31:0] value;
    logic               first_draw;
    logic               last;
  } result_t;

endpackage

FILE: src/rrrs_front.sv
// ----------------------------------------------------------------------------
// Round-robin redraw scheduler: front end
// Accepts requests, drops those that can have no effect and decodes the rest
// into queue entries.
// ----------------------------------------------------------------------------
module rrrs_front #(
  parameter int MAX_WIDGETS = rrrs_pkg::MAX_WIDGETS_DEF,
  parameter int CHANNELS    = rrrs_pkg::CHANNELS_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic [4:0]         in_channel,
  input  logic [4:0]         in_widget_index,
  input  logic signed [31:0] in_value,
  input  logic               in_display_busy,
  input  logic               q_full,
  output logic               q_push,
  output rrrs_pkg::cmd_t     q_data
);

  logic ch_ok;
  logic wi_ok;
  logic keep;

  assign ch_ok = {1'b0, in_channel} < 6'(CHANNELS);
  assign wi_ok = {1'b0, in_widget_index} < 6'(MAX_WIDGETS);

  always_comb begin
    keep                 = 1'b0;
    q_data.op            = rrrs_pkg::OP_SET;
    q_data.channel       = in_channel;
    q_data.widget_index  = in_widget_index;
    q_data.value         = in_value;
    case (in_command)
      rrrs_pkg::CMD_SET: begin
        q_data.op = rrrs_pkg::OP_SET;
        keep      = ch_ok;
      end
      rrrs_pkg::CMD_POLL: begin
        // A poll while the display is busy does nothing at all.
        q_data.op = rrrs_pkg::OP_POLL;
        keep      = !in_display_busy;
      end
      rrrs_pkg::CMD_MAP: begin
        q_data.op = rrrs_pkg::OP_MAP;
        keep      = wi_ok;
      end
      rrrs_pkg::CMD_DRAW: begin
        q_data.op = rrrs_pkg::OP_DRAW;
        keep      = 1'b1;
      end
      rrrs_pkg::CMD_READ: begin
        q_data.op = rrrs_pkg::OP_READ;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

FILE: src/rrrs_queue.sv
// ----------------------------------------------------------------------------
// Round-robin redraw scheduler: command queue
// A short first-in first-out queue of decoded commands.
// ----------------------------------------------------------------------------
module rrrs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rrrs_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output rrrs_pkg::cmd_t head
);

  localparam int DEPTH = rrrs_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  rrrs_pkg::cmd_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CNTW-1:0] count_nxt;

  assign full  = count_r == CNTW'(DEPTH);
  assign valid = count_r != '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/rrrs_back.sv
// ----------------------------------------------------------------------------
// Round-robin redraw scheduler: execution engine
// Holds the channel, map and drawn-value stores, runs the poll scan one
// widget per cycle and the draw-all sweep one widget per cycle while the
// output is not stalled, and drives the output register.
// ----------------------------------------------------------------------------
module rrrs_back #(
  parameter int MAX_WIDGETS = rrrs_pkg::MAX_WIDGETS_DEF,
  parameter int CHANNELS    = rrrs_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [4:0]        cfg_wr_data,
  input  logic              q_valid,
  input  rrrs_pkg::cmd_t    q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output rrrs_pkg::result_t out_res
);

  localparam int WIDX = (MAX_WIDGETS > 1) ? $clog2(MAX_WIDGETS) : 1;
  localparam int CIDX = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNTW = $clog2(MAX_WIDGETS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POLL,
    ST_DRAW
  } state_t;

  // Stores.
  logic signed [31:0] chan_val_r [CHANNELS];
  logic [4:0]         map_r      [MAX_WIDGETS];
  logic signed [31:0] shown_r    [MAX_WIDGETS];
  logic               drawn_r    [MAX_WIDGETS];
  logic [4:0]         widget_count_r;

  // Sequencer.
  state_t            state_r, state_nxt;
  logic [WIDX-1:0]   cursor_r, cursor_nxt;
  logic [WIDX-1:0]   draw_idx_r, draw_idx_nxt;
  logic [CNTW-1:0]   step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  rrrs_pkg::result_t out_res_r, out_res_nxt;

  logic [5:0]         cnt_ext;
  logic [5:0]         n_ext;
  logic [CNTW-1:0]    n_act;
  logic [WIDX-1:0]    scan_idx;
  logic [CNTW-1:0]    scan_inc;
  logic [WIDX-1:0]    scan_next;
  logic [CNTW-1:0]    draw_inc;
  logic               draw_last;
  logic [WIDX-1:0]    widx;
  logic [4:0]         wmap;
  logic signed [31:0] shown;
  logic               drawn;
  logic [4:0]         rd_ch;
  logic signed [31:0] chan_rd;
  logic               hit;
  logic               slot_free;
  logic               chan_we;
  logic               map_we;
  logic               rec_we;

  // Widgets in use, clipped to the size of the widget store.
  assign cnt_ext = {1'b0, widget_count_r};
  assign n_ext   = (cnt_ext > 6'(MAX_WIDGETS)) ? 6'(MAX_WIDGETS) : cnt_ext;
  assign n_act   = CNTW'(n_ext);

  // A cursor left beyond a shrunken count restarts the scan at widget 0.
  assign scan_idx  = (CNTW'(cursor_r) >= n_act) ? '0 : cursor_r;
  assign scan_inc  = CNTW'(scan_idx) + CNTW'(1);
  assign scan_next = (scan_inc == n_act) ? '0 : WIDX'(scan_inc);
  assign draw_inc  = CNTW'(draw_idx_r) + CNTW'(1);
  assign draw_last = draw_inc == n_act;

  assign widx  = (state_r == ST_DRAW) ? draw_idx_r : scan_idx;
  assign wmap  = map_r[widx];
  assign shown = shown_r[widx];
  assign drawn = drawn_r[widx];

  // One channel read port, shared by read requests and by widget lookups.
  // Channels beyond the store read as zero.
  assign rd_ch   = (state_r == ST_IDLE) ? q_head.channel : wmap;
  assign chan_rd = ({1'b0, rd_ch} < 6'(CHANNELS)) ? chan_val_r[rd_ch[CIDX-1:0]] : '0;

  assign hit       = !drawn || (shown != chan_rd);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    draw_idx_nxt  = draw_idx_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    q_pop         = 1'b0;
    chan_we       = 1'b0;
    map_we        = 1'b0;
    rec_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_head.op)
            rrrs_pkg::OP_SET: begin
              q_pop   = 1'b1;
              chan_we = 1'b1;
            end
            rrrs_pkg::OP_MAP: begin
              q_pop  = 1'b1;
              map_we = 1'b1;
            end
            rrrs_pkg::OP_READ: begin
              if (slot_free) begin
                q_pop                  = 1'b1;
                out_valid_nxt          = 1'b1;
                out_res_nxt.kind       = rrrs_pkg::KIND_READ;
                out_res_nxt.widget     = '0;
                out_res_nxt.channel    = q_head.channel;
                out_res_nxt.value      = chan_rd;
                out_res_nxt.first_draw = 1'b0;
                out_res_nxt.last       = 1'b1;
              end
            end
            rrrs_pkg::OP_POLL: begin
              q_pop    = 1'b1;
              step_nxt = '0;
              if (n_act != '0) begin
                state_nxt = ST_POLL;
              end
            end
            rrrs_pkg::OP_DRAW: begin
              q_pop        = 1'b1;
              draw_idx_nxt = '0;
              if (n_act != '0) begin
                state_nxt = ST_DRAW;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_POLL: begin
        if (hit) begin
          // The cursor only moves once the request can be emitted.
          if (slot_free) begin
            rec_we                 = 1'b1;
            cursor_nxt             = scan_next;
            state_nxt              = ST_IDLE;
            out_valid_nxt          = 1'b1;
            out_res_nxt.kind       = rrrs_pkg::KIND_REDRAW;
            out_res_nxt.widget     = 5'(scan_idx);
            out_res_nxt.channel    = wmap;
            out_res_nxt.value      = chan_rd;
            out_res_nxt.first_draw = !drawn;
            out_res_nxt.last       = 1'b1;
          end
        end else begin
          cursor_nxt = scan_next;
          step_nxt   = step_r + CNTW'(1);
          if (step_r + CNTW'(1) == n_act) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DRAW: begin
        if (slot_free) begin
          rec_we                 = 1'b1;
          draw_idx_nxt           = WIDX'(draw_inc);
          out_valid_nxt          = 1'b1;
          out_res_nxt.kind       = rrrs_pkg::KIND_REDRAW;
          out_res_nxt.widget     = 5'(draw_idx_r);
          out_res_nxt.channel    = wmap;
          out_res_nxt.value      = chan_rd;
          out_res_nxt.first_draw = 1'b1;
          out_res_nxt.last       = draw_last;
          if (draw_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      draw_idx_r  <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      draw_idx_r  <= draw_idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widget_count_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        chan_val_r[c] <= '0;
      end
      for (int w = 0; w < MAX_WIDGETS; w++) begin
        map_r[w]   <= '0;
        drawn_r[w] <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        widget_count_r <= cfg_wr_data;
      end
      if (chan_we) begin
        chan_val_r[q_head.channel[CIDX-1:0]] <= q_head.value;
      end
      if (map_we) begin
        map_r[q_head.widget_index[WIDX-1:0]] <= q_head.channel;
      end
      if (rec_we) begin
        drawn_r[widx] <= 1'b1;
      end
    end
  end

  // Drawn values are only read behind a set drawn flag.
  always_ff @(posedge clk) begin
    if (rec_we) begin
      shown_r[widx] <= chan_rd;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: src/round_robin_redraw_scheduler.sv
// ----------------------------------------------------------------------------
// Round-robin redraw scheduler
// Tracks channel values and widget bindings, and hands out widget redraw
// requests in round-robin order or all at once.
// ----------------------------------------------------------------------------
// Usage. Requests enter on the in_ channel (valid/stall) and carry a command:
// set a channel value, poll for the next widget to redraw, bind a widget to a
// channel, draw all widgets, or read a channel back. Results leave on the out_
// channel (valid/stall); out_last marks the final result of a request. The
// widget count is to be written through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block itself does not enforce this. A request passes the
// front end into a two-entry queue in the cycle it is accepted; the engine
// takes requests from the queue only while idle. Set and bind are done when
// the engine takes them. A read shows its result in the cycle after the engine
// takes it. A poll examines one widget per cycle from the cursor on until it
// finds one to redraw or has examined all N widgets in use; a draw-all emits
// one result per widget in use, one per cycle while the output is not stalled.
// Neither emits anything when N is zero. A busy poll and unused codes never
// reach the engine. After reset (rst_n low, synchronous) all channels,
// bindings, drawn flags, the cursor and the widget count are zero. When the
// receiver stalls, the output register holds its result and the engine waits
// at the next emitting step; the queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module round_robin_redraw_scheduler #(
  parameter int MAX_WIDGETS = rrrs_pkg::MAX_WIDGETS_DEF,
  parameter int CHANNELS    = rrrs_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration: widget count in use.
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  // Request channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic [4:0]         in_channel,
  input  logic [4:0]         in_widget_index,
  input  logic signed [31:0] in_value,
  input  logic               in_display_busy,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [4:0]         out_widget_out,
  output logic [4:0]         out_channel_out,
  output logic signed [31:0] out_value_out,
  output logic               out_first_draw,
  output logic               out_last
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  rrrs_pkg::cmd_t    q_data;
  rrrs_pkg::cmd_t    q_head;
  rrrs_pkg::result_t res;

  // The front end drops requests that cannot have any effect (a busy poll,
  // a set or bind out of range, unused codes) so they never reach the queue.
  rrrs_front #(
    .MAX_WIDGETS(MAX_WIDGETS),
    .CHANNELS   (CHANNELS)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_channel     (in_channel),
    .in_widget_index(in_widget_index),
    .in_value       (in_value),
    .in_display_busy(in_display_busy),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_data)
  );

  // The queue decouples intake from execution so requests keep arriving
  // while a scan or a draw-all sweep is in progress.
  rrrs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_data),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // The engine executes requests strictly in order, which keeps channel
  // updates and redraw requests consistent with the order of arrival.
  rrrs_back #(
    .MAX_WIDGETS(MAX_WIDGETS),
    .CHANNELS   (CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign out_kind        = res.kind;
  assign out_widget_out  = res.widget;
  assign out_channel_out = res.channel;
  assign out_value_out   = res.value;
  assign out_first_draw  = res.first_draw;
  assign out_last        = res.last;

endmodule
